/* design/mbfe_pkg.sv */
// Shared types and constants for the mask boundary face extractor.
// Used by every module of the block; no dependencies.
`default_nettype none

package mbfe_pkg;

  // Fixed field widths
  localparam int DIM_W      = 11;  // grid size registers and row/column counters
  localparam int VTX_W      = 22;  // vertex index
  localparam int ROWBASE_W  = 21;  // first vertex index of the current row
  localparam int LBL_W      = 8;   // patch label on the output side
  localparam int IN_DATA_W  = 8;   // in_tdata: cell_label
  localparam int OUT_DATA_W = 80;  // out_tdata: three vertices and label, padded
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_LABEL = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_LABEL   = 2'd3;

  // Register values after reset
  localparam logic [DIM_W-1:0] RST_GRID_WIDTH   = 11'd1;
  localparam logic [DIM_W-1:0] RST_GRID_HEIGHT  = 11'd1;
  localparam logic [LBL_W-1:0] RST_BOTTOM_LABEL = 8'd10;
  localparam logic [LBL_W-1:0] RST_SIDE_LABEL   = 8'd11;

  // Input kind codes
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_PAD  = 1'b1;

  // Faces in emission order
  typedef enum logic [2:0] {
    FACE_TOP    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_t;

  localparam int NUM_FACES = 6;

  // Corner codes per triangle: bit0 x offset, bit1 y offset, bit2 top plane
  localparam logic [2:0] FACE_CORNERS [12][3] = '{
    '{3'd4, 3'd5, 3'd7}, '{3'd4, 3'd7, 3'd6},  // top
    '{3'd0, 3'd3, 3'd1}, '{3'd0, 3'd2, 3'd3},  // bottom
    '{3'd0, 3'd4, 3'd2}, '{3'd4, 3'd6, 3'd2},  // left
    '{3'd3, 3'd5, 3'd1}, '{3'd5, 3'd3, 3'd7},  // right
    '{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd4},  // front
    '{3'd7, 3'd3, 3'd2}, '{3'd6, 3'd7, 3'd2}   // back
  };

  // Front-end state
  typedef enum logic {
    FS_IDLE = 1'b0,
    FS_EVAL = 1'b1
  } front_state_t;

  // Effective geometry and labels, from the configuration registers
  typedef struct packed {
    logic [DIM_W-1:0] width;         // clamped grid width
    logic [DIM_W-1:0] height;        // clamped grid height
    logic [DIM_W:0]   row_step;      // width + 1
    logic [VTX_W-1:0] plane;         // (width + 1) * (height + 1), wrapped
    logic [LBL_W-1:0] bottom_label;
    logic [LBL_W-1:0] side_label;
  } geom_t;

  // One cell that emits triangles, handed from the front to the back
  typedef struct packed {
    logic [VTX_W-1:0] base;       // row base + column
    logic [LBL_W-1:0] top_label;  // the cell's own label
    logic [3:0]       sides;      // exposed faces: back, front, right, left
  } cell_desc_t;

endpackage

`default_nettype wire

/* design/mbfe_front.sv */
// Front end: accepts mask items, keeps the two row stores and the raster
// counters, and classifies each delayed cell into a face descriptor.
// Depends on mbfe_pkg.
`default_nettype none

module mbfe_front import mbfe_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire geom_t            geom,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_kind,
  input  wire logic [LBL_W-1:0] in_label,
  output logic                  push,
  output cell_desc_t            desc,
  input  wire logic             full
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Row stores: older holds the row before the cell's row, newer the cell's row
  logic [LABEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [LABEL_BITS-1:0] newer_mem [MAX_WIDTH];

  front_state_t state_r, state_nxt;
  logic [DIM_W-1:0]     col_r, col_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [ROWBASE_W-1:0] base_r, base_nxt;

  logic [DIM_W-1:0]      x_r;
  logic [LABEL_BITS-1:0] lab_r;
  logic                  flush_r;

  logic [LABEL_BITS-1:0] front_q, left_q, self_q, right_q;

  logic                  accept;
  logic                  rd_en, wr_en;
  logic [DIM_W-1:0]      x_sel;
  logic                  flush_sel;
  logic [LABEL_BITS-1:0] lab_sel;
  logic [DIM_W:0]        x_inc;
  logic                  row_end;
  logic                  emit;
  logic                  left_open, right_open, front_open, back_open;
  logic [2*DIM_W+1:0]    row_prod;

  // Column for the incoming item, restarted if the width shrank
  always_comb begin
    x_sel     = (col_r >= geom.width) ? '0 : col_r;
    flush_sel = (row_r >= geom.height);
    lab_sel   = (flush_sel || in_kind == KIND_PAD) ? '0 : LABEL_BITS'(in_label);
  end

  // Classify the delayed cell from the registered store reads
  always_comb begin
    x_inc      = {1'b0, x_r} + 1'b1;
    row_end    = (x_inc >= {1'b0, geom.width});
    emit       = (row_r != '0) && (self_q != '0);
    left_open  = (x_r == '0) || (left_q == '0);
    right_open = row_end || (right_q == '0);
    front_open = (row_r == DIM_W'(1)) || (front_q == '0);
    back_open  = flush_r || (lab_r == '0);
    row_prod   = row_r * geom.row_step;
    desc.base      = VTX_W'(base_r) + VTX_W'(x_r);
    desc.top_label = LBL_W'(self_q);
    desc.sides     = {back_open, front_open, right_open, left_open};
  end

  // Sequence: accept and read, then evaluate, write back and hand off
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept    = 1'b1;
          rd_en     = 1'b1;
          state_nxt = FS_EVAL;
        end
      end
      FS_EVAL: begin
        if (!(emit && full)) begin
          push      = emit;
          wr_en     = 1'b1;
          state_nxt = FS_IDLE;
          if (row_end) begin
            col_nxt = '0;
            if (flush_r) begin
              row_nxt  = '0;
              base_nxt = '0;
            end else begin
              base_nxt = row_prod[ROWBASE_W-1:0];
              row_nxt  = row_r + 1'b1;
            end
          end else begin
            col_nxt = x_inc[DIM_W-1:0];
          end
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      base_r  <= base_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= x_sel;
      lab_r   <= lab_sel;
      flush_r <= flush_sel;
    end
  end

  // Row stores: read on accept, shift the column down on write-back
  always_ff @(posedge clk) begin
    if (rd_en) begin
      front_q <= older_mem[AW'(x_sel)];
      left_q  <= older_mem[AW'(x_sel - 1'b1)];
      self_q  <= newer_mem[AW'(x_sel)];
      right_q <= newer_mem[AW'(x_sel + 1'b1)];
    end
    if (wr_en) begin
      older_mem[AW'(x_r)] <= self_q;
      newer_mem[AW'(x_r)] <= lab_r;
    end
  end

endmodule

`default_nettype wire

/* design/mbfe_fifo.sv */
// Two-entry queue of cell descriptors between the front and back ends.
// Depends on mbfe_pkg.
`default_nettype none

module mbfe_fifo import mbfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire cell_desc_t wr_data,
  output logic            full,
  input  wire logic       pop,
  output cell_desc_t      rd_data,
  output logic            empty
);

  cell_desc_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  always_comb begin
    full    = (count_r == 2'd2);
    empty   = (count_r == 2'd0);
    rd_data = entry_r[rd_ptr_r];
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

/* design/mbfe_back.sv */
// Back end: walks the faces of one descriptor, two triangles per face,
// and drives the registered result channel.
// Depends on mbfe_pkg.
`default_nettype none

module mbfe_back import mbfe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire geom_t                 geom,
  input  wire cell_desc_t            desc,
  input  wire logic                  empty,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_last
);

  cell_desc_t cur_r;
  logic       busy_r;
  face_t      face_r, face_nxt;
  logic       tri_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic [NUM_FACES-1:0] face_en;
  logic                 has_next;
  logic                 slot_free;
  logic                 fire;
  logic                 last_tri;
  logic [3:0]           tri_idx;
  logic [VTX_W-1:0]     vtx [3];
  logic [LBL_W-1:0]     label;

  // Corner code to vertex index
  function automatic logic [VTX_W-1:0] corner_vertex(
    input logic [VTX_W-1:0] base,
    input logic [2:0]       code,
    input logic [DIM_W:0]   row_step,
    input logic [VTX_W-1:0] plane
  );
    logic [VTX_W-1:0] v;
    v = base + VTX_W'(code[0]);
    if (code[1]) v = v + VTX_W'(row_step);
    if (code[2]) v = v + plane;
    return v;
  endfunction

  // Find the next face to emit after the current one
  always_comb begin
    face_en  = {cur_r.sides, 2'b11};
    has_next = 1'b0;
    face_nxt = face_r;
    for (int g = NUM_FACES - 1; g >= 0; g--) begin
      if (g > int'(face_r) && face_en[g]) begin
        has_next = 1'b1;
        face_nxt = face_t'(g);
      end
    end
  end

  // Build the current triangle
  always_comb begin
    tri_idx = {face_r, tri_r};
    for (int c = 0; c < 3; c++) begin
      vtx[c] = corner_vertex(cur_r.base, FACE_CORNERS[tri_idx][c], geom.row_step,
                             geom.plane);
    end
    case (face_r)
      FACE_TOP:    label = cur_r.top_label;
      FACE_BOTTOM: label = geom.bottom_label;
      default:     label = geom.side_label;
    endcase
    last_tri  = tri_r && !has_next;
    slot_free = !out_valid_r || out_ready;
    fire      = busy_r && slot_free;
    pop       = !busy_r && !empty;
  end

  // Walk faces and triangles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      face_r <= FACE_TOP;
      tri_r  <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
      face_r <= FACE_TOP;
      tri_r  <= 1'b0;
    end else if (fire) begin
      if (last_tri) begin
        busy_r <= 1'b0;
      end else if (tri_r) begin
        face_r <= face_nxt;
        tri_r  <= 1'b0;
      end else begin
        tri_r <= 1'b1;
      end
    end
  end

  // Latch the descriptor being walked
  always_ff @(posedge clk) begin
    if (pop) cur_r <= desc;
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {{(OUT_DATA_W - 3*VTX_W - LBL_W){1'b0}}, label, vtx[2], vtx[1], vtx[0]};
      out_last_r <= last_tri;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

/* design/mask_boundary_face_extractor.sv */
// Mask boundary face extractor: cuberille faces of a one-layer label mask.
// A cell's triangles follow the acceptance of the cell one row below it. The
// front reads the row stores for an item, then writes back and hands off, and
// waits while the queue is full; the back loads each non-empty cell and then
// emits one triangle a cycle while out_tready does not hold the result channel.
// Reset (rst_n low, synchronous) clears counters, queue and handshakes and loads
// register defaults; the row stores are not cleared.
`default_nettype none

module mask_boundary_face_extractor import mbfe_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int LABEL_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] cell_label
  input  wire logic                  in_tuser,   // [0] kind
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [21:0] vertex_first,
                                                 // [43:22] vertex_second,
                                                 // [65:44] vertex_third,
                                                 // [73:66] patch_label, rest zero
  output logic                       out_tlast,  // last_of_cell
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0] grid_width_r, grid_height_r;
  logic [LBL_W-1:0] bottom_label_r, side_label_r;
  logic [VTX_W-1:0] plane_r;

  logic [DIM_W-1:0]   width_eff, height_eff;
  logic [DIM_W:0]     row_step;
  logic [2*DIM_W+1:0] plane_full;
  geom_t              geom;

  logic       push, full, pop, empty;
  cell_desc_t front_desc, queue_desc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= RST_GRID_WIDTH;
      grid_height_r  <= RST_GRID_HEIGHT;
      bottom_label_r <= RST_BOTTOM_LABEL;
      side_label_r   <= RST_SIDE_LABEL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_WIDTH:   grid_width_r   <= cfg_wdata;
        REG_GRID_HEIGHT:  grid_height_r  <= cfg_wdata;
        REG_BOTTOM_LABEL: bottom_label_r <= cfg_wdata[LBL_W-1:0];
        REG_SIDE_LABEL:   side_label_r   <= cfg_wdata[LBL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size and derive the vertex strides
  always_comb begin
    if (grid_width_r == '0) width_eff = DIM_W'(1);
    else if (32'(grid_width_r) > MAX_WIDTH) width_eff = DIM_W'(MAX_WIDTH);
    else width_eff = grid_width_r;
    if (grid_height_r == '0) height_eff = DIM_W'(1);
    else if (32'(grid_height_r) > MAX_HEIGHT) height_eff = DIM_W'(MAX_HEIGHT);
    else height_eff = grid_height_r;
    row_step   = {1'b0, width_eff} + 1'b1;
    plane_full = row_step * ({1'b0, height_eff} + 1'b1);
    geom.width        = width_eff;
    geom.height       = height_eff;
    geom.row_step     = row_step;
    geom.plane        = plane_r;
    geom.bottom_label = bottom_label_r;
    geom.side_label   = side_label_r;
  end

  // Register the plane offset; only the back end uses it
  always_ff @(posedge clk) begin
    plane_r <= plane_full[VTX_W-1:0];
  end

  mbfe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_label (in_tdata[LBL_W-1:0]),
    .push     (push),
    .desc     (front_desc),
    .full     (full)
  );

  mbfe_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_desc),
    .full    (full),
    .pop     (pop),
    .rd_data (queue_desc),
    .empty   (empty)
  );

  mbfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .desc      (queue_desc),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
